@@ src/pac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pac_pkg: shared types and constants of the park actuator controller
// Zone codes, drive and target codes, gear codes, register indexes and the
// sequencer state types used by the top level and the serial arithmetic unit.
// ----------------------------------------------------------------------------
package pac_pkg;

    // drive direction and latched target share one code space
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic [7:0] GEAR_PARK   = 8'h01;
    localparam logic [7:0] GEAR_UNPARK = 8'h02;

    localparam logic [3:0] ZONE_LEFT_STOP   = 4'd0;
    localparam logic [3:0] ZONE_LEFT_HIGH   = 4'd1;
    localparam logic [3:0] ZONE_HIGH        = 4'd2;
    localparam logic [3:0] ZONE_RIGHT_HIGH  = 4'd3;
    localparam logic [3:0] ZONE_ONE         = 4'd4;
    localparam logic [3:0] ZONE_HIGH_LOCK   = 4'd5;
    localparam logic [3:0] ZONE_TWO         = 4'd6;
    localparam logic [3:0] ZONE_LOW         = 4'd7;
    localparam logic [3:0] ZONE_RIGHT_STOP  = 4'd8;
    localparam logic [3:0] ZONE_ERR         = 4'd9;

    // sensor pattern to zone, indexed by the four sensor bits
    localparam logic [3:0] ZONE_TABLE [16] = '{
        ZONE_ERR, ZONE_ERR, ZONE_ERR, ZONE_ERR,
        ZONE_ERR, ZONE_LOW, ZONE_HIGH_LOCK, ZONE_TWO,
        ZONE_LEFT_STOP, ZONE_ERR, ZONE_LEFT_HIGH, ZONE_HIGH,
        ZONE_ERR, ZONE_RIGHT_STOP, ZONE_ONE, ZONE_RIGHT_HIGH
    };

    localparam logic [3:0]  HOLD_TICKS  = 4'd10;
    localparam logic [3:0]  HOLD_MAX    = 4'd15;
    localparam logic [16:0] SPEED_LIMIT = 17'd200;
    localparam logic [15:0] DUTY_LIMIT  = 16'd10000;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W     = 4;
    localparam logic [3:0]  REG_VOLT_BASE = 4'd0;
    localparam logic [3:0]  REG_DUTY_BASE = 4'd4;
    localparam logic [3:0]  REG_COUNT     = 4'd8;

    localparam logic [15:0] VOLT_RESET [4] = '{16'd9000, 16'd11000, 16'd13000, 16'd15000};
    localparam logic [15:0] DUTY_RESET [4] = '{16'd6000, 16'd5000, 16'd4000, 16'd3000};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_SETUP,
        ST_CALC,
        ST_DONE
    } t_state;

    // voltage segment found by the breakpoint search
    typedef enum logic [2:0] {
        SEG_BELOW,
        SEG_0,
        SEG_1,
        SEG_2,
        SEG_TOP
    } t_seg;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_md_status;

endpackage

`default_nettype wire

@@ src/pac_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pac_if: channel interfaces of the park actuator controller
// Tick input channel, drive result channel and configuration write channel,
// each with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface pac_in_if;
    logic               valid;
    logic               ready;
    logic               system_ready;
    logic [7:0]         gear_request;
    logic signed [15:0] vehicle_speed;
    logic               motor_running;
    logic [15:0]        ign_voltage;
    logic [3:0]         sensor_bits;
    logic               clear_finished;

    modport source (
        output valid, system_ready, gear_request, vehicle_speed, motor_running,
               ign_voltage, sensor_bits, clear_finished,
        input  ready
    );
    modport sink (
        input  valid, system_ready, gear_request, vehicle_speed, motor_running,
               ign_voltage, sensor_bits, clear_finished,
        output ready
    );
endinterface

interface pac_out_if;
    logic        valid;
    logic        ready;
    logic        drive_valid;
    logic [1:0]  drive_dir;
    logic [15:0] drive_duty;
    logic [3:0]  position_zone;
    logic        action_finished;
    logic [1:0]  target_cmd;

    modport source (
        output valid, drive_valid, drive_dir, drive_duty, position_zone,
               action_finished, target_cmd,
        input  ready
    );
    modport sink (
        input  valid, drive_valid, drive_dir, drive_duty, position_zone,
               action_finished, target_cmd,
        output ready
    );
endinterface

interface pac_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pac_pkg::CFG_IDX_W-1:0]   index;
    logic [15:0]                     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/pac_muldiv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pac_muldiv: bit-serial multiply then divide
// Computes (mcand * mplier) / den one bit per cycle: 16 shift-add steps build
// the product, 16 restoring steps divide it. The caller guarantees
// mplier < den, so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module pac_muldiv (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [15:0]         i_mcand,
    input  wire logic [15:0]         i_mplier,
    input  wire logic [15:0]         i_den,
    output pac_pkg::t_md_status      o_status,
    output logic [15:0]              o_quot
);

    pac_pkg::t_md_state r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_done, n_done;
    logic [15:0] r_hi, n_hi;
    logic [15:0] r_lo, n_lo;
    logic [15:0] r_mcand;
    logic [15:0] r_den;

    logic [16:0] mul_sum;
    logic [16:0] div_trial;
    logic [16:0] div_diff;
    logic        div_ge;

    always_comb begin
        mul_sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : 17'd0);
        div_trial = {r_hi, r_lo[15]};
        div_diff  = div_trial - {1'b0, r_den};
        div_ge    = (div_trial >= {1'b0, r_den});

        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_hi    = r_hi;
        n_lo    = r_lo;
        unique case (r_state)
            pac_pkg::MD_IDLE: begin
                if (i_start) begin
                    n_state = pac_pkg::MD_MUL;
                    n_cnt   = '0;
                    n_hi    = '0;
                    n_lo    = i_mplier;
                end
            end
            pac_pkg::MD_MUL: begin
                // add the multiplicand on the low bit, then shift the pair right
                n_hi  = mul_sum[16:1];
                n_lo  = {mul_sum[0], r_lo[15:1]};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = pac_pkg::MD_DIV;
                end
            end
            pac_pkg::MD_DIV: begin
                // remainder stays below den, so a non-restored trial fits 16 bits
                n_hi  = div_ge ? div_diff[15:0] : div_trial[15:0];
                n_lo  = {r_lo[14:0], div_ge};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = pac_pkg::MD_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = pac_pkg::MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pac_pkg::MD_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
        if (r_state == pac_pkg::MD_IDLE && i_start) begin
            r_mcand <= i_mcand;
            r_den   <= i_den;
        end
    end

    assign o_status.busy = (r_state != pac_pkg::MD_IDLE);
    assign o_status.done = r_done;
    assign o_quot        = r_lo;

endmodule

`default_nettype wire

@@ src/park_actuator_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// sequencing: an input beat goes through SEL and SETUP to DONE when the voltage
//   lies below the first or at/above the last breakpoint, else through CALC too
// input: a new tick is accepted only in IDLE, after the result commits;
//   CALC uses pac_muldiv: 16-step serial multiply, 16-step restoring divide
// reset: synchronous active-low; breakpoints and duties return to defaults,
//   target to stop, finished flag and hold counter to zero
// ----------------------------------------------------------------------------
// park_actuator_controller: park actuator control tick
// Decodes the position sensors, interpolates the park duty from ignition
// voltage, latches the gear target and applies the park/unpark zone rules.
// ----------------------------------------------------------------------------
module park_actuator_controller (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pac_in_if.sink      i_in,
    pac_out_if.source   o_out,
    pac_cfg_if.sink     i_cfg
);

    pac_pkg::t_state r_state, n_state;

    // configuration
    logic [15:0] r_volt [4];
    logic [15:0] r_duty [4];

    // captured tick
    logic               r_sys_ready;
    logic [7:0]         r_gear;
    logic signed [15:0] r_speed;
    logic               r_running;
    logic [15:0]        r_vin;
    logic [3:0]         r_sensor;
    logic               r_clear;

    pac_pkg::t_seg r_seg;
    logic [15:0]   r_d0;
    logic          r_neg;
    logic [15:0]   r_duty_val;

    // control state
    logic [1:0] r_tgt, n_tgt;
    logic       r_fin, n_fin;
    logic [3:0] r_hold, n_hold;

    // result register
    logic        r_out_valid, n_out_valid;
    logic        r_drv_valid;
    logic [1:0]  r_drv_dir;
    logic [15:0] r_drv_duty;
    logic [3:0]  r_zone;
    logic        r_out_fin;
    logic [1:0]  r_out_tgt;

    logic        in_beat;
    logic        commit;
    logic        md_start;
    pac_pkg::t_seg seg_found;

    logic [15:0] lo_v, hi_v, d0, d1;
    logic [15:0] op_mag, op_dv, op_den;

    pac_pkg::t_md_status md_status;
    logic [15:0]         md_quot;

    logic [15:0] duty_clamp;
    logic [16:0] spd_mag;
    logic        spd_ok;
    logic [3:0]  zone;
    logic        drv_valid;
    logic [1:0]  drv_dir;
    logic [15:0] drv_duty;

    assign in_beat     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == pac_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // breakpoint search, highest qualifying breakpoint wins
    always_comb begin
        priority if (r_vin >= r_volt[3]) begin
            seg_found = pac_pkg::SEG_TOP;
        end else if (r_vin >= r_volt[2]) begin
            seg_found = pac_pkg::SEG_2;
        end else if (r_vin >= r_volt[1]) begin
            seg_found = pac_pkg::SEG_1;
        end else if (r_vin >= r_volt[0]) begin
            seg_found = pac_pkg::SEG_0;
        end else begin
            seg_found = pac_pkg::SEG_BELOW;
        end
    end

    // segment operands
    always_comb begin
        unique case (r_seg)
            pac_pkg::SEG_1: begin
                lo_v = r_volt[1]; hi_v = r_volt[2]; d0 = r_duty[1]; d1 = r_duty[2];
            end
            pac_pkg::SEG_2: begin
                lo_v = r_volt[2]; hi_v = r_volt[3]; d0 = r_duty[2]; d1 = r_duty[3];
            end
            pac_pkg::SEG_TOP: begin
                lo_v = r_volt[0]; hi_v = r_volt[1]; d0 = r_duty[3]; d1 = r_duty[3];
            end
            default: begin
                lo_v = r_volt[0]; hi_v = r_volt[1]; d0 = r_duty[0]; d1 = r_duty[1];
            end
        endcase
        op_mag = (d0 >= d1) ? (d0 - d1) : (d1 - d0);
        op_dv  = r_vin - lo_v;
        op_den = hi_v - lo_v;
    end

    pac_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (md_start),
        .i_mcand  (op_mag),
        .i_mplier (op_dv),
        .i_den    (op_den),
        .o_status (md_status),
        .o_quot   (md_quot)
    );

    // zone rules for the tick in the result stage
    always_comb begin
        duty_clamp = (r_duty_val > pac_pkg::DUTY_LIMIT) ? pac_pkg::DUTY_LIMIT : r_duty_val;
        spd_mag    = r_speed[15] ? (17'd0 - {r_speed[15], r_speed})
                                 : {1'b0, r_speed};
        spd_ok     = (spd_mag <= pac_pkg::SPEED_LIMIT);
        zone       = pac_pkg::ZONE_TABLE[r_sensor];

        n_tgt     = r_tgt;
        n_fin     = r_clear ? 1'b0 : r_fin;
        n_hold    = r_hold;
        drv_valid = 1'b0;
        drv_dir   = pac_pkg::DIR_STOP;
        drv_duty  = '0;

        if (r_sys_ready) begin
            if (!r_running) begin
                if (r_gear == pac_pkg::GEAR_PARK) begin
                    n_tgt = spd_ok ? pac_pkg::DIR_REV : pac_pkg::DIR_STOP;
                end else if (r_gear == pac_pkg::GEAR_UNPARK) begin
                    n_tgt = pac_pkg::DIR_FWD;
                end
            end

            priority if (n_tgt == pac_pkg::DIR_FWD) begin
                if (zone <= pac_pkg::ZONE_HIGH_LOCK) begin
                    drv_valid = 1'b1;
                    drv_dir   = pac_pkg::DIR_FWD;
                    drv_duty  = duty_clamp;
                end else if (zone == pac_pkg::ZONE_TWO) begin
                    drv_valid = 1'b1;
                    n_fin     = 1'b1;
                end else if (zone <= pac_pkg::ZONE_RIGHT_STOP) begin
                    drv_valid = 1'b1;
                    drv_dir   = pac_pkg::DIR_REV;
                    drv_duty  = {1'b0, duty_clamp[15:1]};
                end
            end else if (n_tgt == pac_pkg::DIR_REV) begin
                if (zone <= pac_pkg::ZONE_LEFT_HIGH) begin
                    drv_valid = 1'b1;
                    drv_dir   = pac_pkg::DIR_FWD;
                    drv_duty  = {1'b0, duty_clamp[15:1]};
                    n_fin     = 1'b1;
                end else if (zone == pac_pkg::ZONE_HIGH) begin
                    // hold at the high position before stopping
                    if (r_hold >= pac_pkg::HOLD_TICKS || n_fin) begin
                        drv_valid = 1'b1;
                        n_hold    = '0;
                        n_fin     = 1'b1;
                    end else if (r_hold < pac_pkg::HOLD_MAX) begin
                        n_hold = r_hold + 4'd1;
                    end
                end else if (zone <= pac_pkg::ZONE_RIGHT_STOP) begin
                    drv_valid = 1'b1;
                    drv_dir   = pac_pkg::DIR_REV;
                    drv_duty  = duty_clamp;
                end
            end else begin
                drv_valid = 1'b1;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        md_start = 1'b0;
        commit   = 1'b0;
        unique case (r_state)
            pac_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_state = pac_pkg::ST_SEL;
                end
            end
            pac_pkg::ST_SEL: begin
                n_state = pac_pkg::ST_SETUP;
            end
            pac_pkg::ST_SETUP: begin
                if (r_seg == pac_pkg::SEG_BELOW || r_seg == pac_pkg::SEG_TOP) begin
                    n_state = pac_pkg::ST_DONE;
                end else begin
                    md_start = 1'b1;
                    n_state  = pac_pkg::ST_CALC;
                end
            end
            pac_pkg::ST_CALC: begin
                if (md_status.done) begin
                    n_state = pac_pkg::ST_DONE;
                end
            end
            pac_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    commit  = 1'b1;
                    n_state = pac_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pac_pkg::ST_IDLE;
            end
        endcase
        n_out_valid = commit ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pac_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_tgt       <= pac_pkg::DIR_STOP;
            r_fin       <= 1'b0;
            r_hold      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (commit) begin
                r_tgt  <= n_tgt;
                r_fin  <= n_fin;
                r_hold <= n_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_volt[k] <= pac_pkg::VOLT_RESET[k];
                r_duty[k] <= pac_pkg::DUTY_RESET[k];
            end
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index < pac_pkg::REG_DUTY_BASE) begin
                r_volt[i_cfg.index[1:0]] <= i_cfg.data;
            end else if (i_cfg.index < pac_pkg::REG_COUNT) begin
                r_duty[i_cfg.index[1:0]] <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_sys_ready <= i_in.system_ready;
            r_gear      <= i_in.gear_request;
            r_speed     <= i_in.vehicle_speed;
            r_running   <= i_in.motor_running;
            r_vin       <= i_in.ign_voltage;
            r_sensor    <= i_in.sensor_bits;
            r_clear     <= i_in.clear_finished;
        end
        if (r_state == pac_pkg::ST_SEL) begin
            r_seg <= seg_found;
        end
        if (r_state == pac_pkg::ST_SETUP) begin
            r_d0       <= d0;
            r_neg      <= (d0 < d1);
            r_duty_val <= d0;
        end
        if (r_state == pac_pkg::ST_CALC && md_status.done) begin
            r_duty_val <= r_neg ? (r_d0 + md_quot) : (r_d0 - md_quot);
        end
        if (commit) begin
            r_drv_valid <= drv_valid;
            r_drv_dir   <= drv_dir;
            r_drv_duty  <= drv_duty;
            r_zone      <= zone;
            r_out_fin   <= n_fin;
            r_out_tgt   <= n_tgt;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.drive_valid     = r_drv_valid;
    assign o_out.drive_dir       = r_drv_dir;
    assign o_out.drive_duty      = r_drv_duty;
    assign o_out.position_zone   = r_zone;
    assign o_out.action_finished = r_out_fin;
    assign o_out.target_cmd      = r_out_tgt;

    a_beat_starts_search: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> r_state == pac_pkg::ST_SEL
    ) else $error("input beat did not start the breakpoint search");

    a_muldiv_in_calc: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (md_status.busy || md_status.done) |-> r_state == pac_pkg::ST_CALC
    ) else $error("serial unit active outside the calculation state");

    a_hold_only_on_commit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pac_pkg::ST_DONE) |=> $stable(r_hold) && $stable(r_tgt)
    ) else $error("control state changed outside the result stage");

    a_no_drive_no_duty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.drive_valid)
            |-> (o_out.drive_duty == 16'd0 && o_out.drive_dir == pac_pkg::DIR_STOP)
    ) else $error("duty or direction reported without a drive command");

endmodule

`default_nettype wire
